// ===== rtl/cba_pkg.sv =====
package cba_pkg;

   localparam int NUM_BLOCKS    = 4096;
   localparam int BLOCK_PAYLOAD = 4090;

   localparam int BLK_W   = 12;
   localparam int BYTES_W = 24;
   localparam int STEP_W  = $clog2(NUM_BLOCKS) + 1;

   // free bitmap is stored as rows of MAP_W bits, one bit per block
   localparam int MAP_W     = 64;
   localparam int MAP_BIT_W = $clog2(MAP_W);
   localparam int MAP_ROWS  = NUM_BLOCKS / MAP_W;
   localparam int ROW_W     = $clog2(MAP_ROWS);

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_FREE   = 2'd1;
   localparam logic [1:0] FUNC_NEXT   = 2'd2;

   typedef struct packed {
      logic             rd;
      logic             wr;
      logic [ROW_W-1:0] row;
      logic [MAP_W-1:0] wdata;
   } map_req_type;

   // lowest set bit position; 0 when none is set
   function automatic logic [MAP_BIT_W-1:0] find_first(input logic [MAP_W-1:0] v);
      logic [MAP_BIT_W-1:0] pos;
      pos = '0;
      for (int i = MAP_W - 1; i >= 0; i--) begin
         if (v[i]) pos = MAP_BIT_W'(i);
      end
      return pos;
   endfunction

endpackage

// ===== rtl/cba_ram.sv =====
module cba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/cba_map.sv =====
// Free bitmap: row memory, per-row written flags and per-row any-free summary.
module cba_map (
   input  logic                          clock,
   input  logic                          reset,
   input  cba_pkg::map_req_type          req,
   output logic [cba_pkg::MAP_W-1:0]     rdata,
   output logic                          any_free,
   output logic [cba_pkg::ROW_W-1:0]     free_row
);

   logic [cba_pkg::MAP_ROWS-1:0] valid_ff;
   logic [cba_pkg::MAP_ROWS-1:0] has_free_ff;
   logic [cba_pkg::ROW_W-1:0]    rd_row_ff;
   logic                         rd_valid_ff;
   logic [cba_pkg::MAP_W-1:0]    ram_rdata;
   logic [cba_pkg::MAP_W-1:0]    reset_row;

   cba_ram #(
      .WIDTH(cba_pkg::MAP_W),
      .DEPTH(cba_pkg::MAP_ROWS)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (req.wr),
      .wr_addr(req.row),
      .wr_data(req.wdata),
      .rd_en  (req.rd),
      .rd_addr(req.row),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         has_free_ff <= '1;
      end else if (req.wr) begin
         valid_ff[req.row]    <= 1'b1;
         has_free_ff[req.row] <= |req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd) begin
         rd_row_ff   <= req.row;
         rd_valid_ff <= valid_ff[req.row];
      end
   end

   // unwritten rows read as the reset pattern; block 0 is never free
   assign reset_row = (rd_row_ff == '0) ? ~cba_pkg::MAP_W'(1) : '1;
   assign rdata     = rd_valid_ff ? ram_rdata : reset_row;
   assign any_free  = |has_free_ff;
   assign free_row  = cba_pkg::ROW_W'(cba_pkg::find_first(cba_pkg::MAP_W'(has_free_ff)));

endmodule

// ===== rtl/chained_block_allocator_core.sv =====
// Append: accept with bitmap row read, allocate, link, then the result register.
// Next request: next-table read, then the result register. Free, per walked block:
// next-table and bitmap read, then bitmap write-back; full, no-op and block-0 requests go straight to the result.
// One transaction in work at a time; the next is taken while the result waits.
// Reset: synchronous, clears the bitmap row flags at once (no clearing pass);
// the next-pointer table is not cleared.
module chained_block_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // new_chain[0], block[12:1], byte_count[24:13], zero[31:25]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // result_block[11:0], head_block[23:12],
                                   // chain_bytes[47:24], freed_count[59:48], zero[63:60]
   output logic        rsp_tuser   // full_res
);

   localparam int BW = cba_pkg::BLK_W;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_APP_ALLOC = 3'd1;
   localparam logic [2:0] S_APP_LINK  = 3'd2;
   localparam logic [2:0] S_NXT_WAIT  = 3'd3;
   localparam logic [2:0] S_FREE_RD   = 3'd4;
   localparam logic [2:0] S_FREE_UPD  = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [BW-1:0]                  prev_ff, prev_in;
   logic [BW-1:0]                  head_ff, head_in;
   logic [cba_pkg::BYTES_W-1:0]    total_ff, total_in;
   logic                           new_chain_ff, new_chain_in;
   logic [BW-1:0]                  bytes_ff, bytes_in;
   logic [cba_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [BW-1:0]                  res_block_ff, res_block_in;
   logic                           full_ff, full_in;
   logic [BW-1:0]                  freed_ff, freed_in;
   logic [BW-1:0]                  walk_ff, walk_in;
   logic [BW-1:0]                  link_ff, link_in;
   logic [cba_pkg::STEP_W-1:0]     steps_ff, steps_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]                    rsp_tdata_ff, rsp_tdata_in;
   logic                           rsp_tuser_ff, rsp_tuser_in;

   logic [1:0]                     req_func;
   logic                           req_new_chain;
   logic [BW-1:0]                  req_block;
   logic [BW-1:0]                  req_bytes;

   cba_pkg::map_req_type           map_req;
   logic [cba_pkg::MAP_W-1:0]      map_rdata;
   logic                           any_free;
   logic [cba_pkg::ROW_W-1:0]      free_row;

   logic                           nxt_we, nxt_re;
   logic [BW-1:0]                  nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;

   logic                           out_free;
   logic [cba_pkg::MAP_BIT_W-1:0]  alloc_bit;
   logic [BW-1:0]                  alloc_blk;
   logic [BW-1:0]                  bytes_sat;
   logic [cba_pkg::BYTES_W-1:0]    total_base;
   logic [cba_pkg::BYTES_W:0]      total_sum;

   assign req_func      = req_tuser;
   assign req_new_chain = req_tdata[0];
   assign req_block     = req_tdata[12:1];
   assign req_bytes     = req_tdata[24:13];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   cba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .req     (map_req),
      .rdata   (map_rdata),
      .any_free(any_free),
      .free_row(free_row)
   );

   cba_ram #(
      .WIDTH(BW),
      .DEPTH(cba_pkg::NUM_BLOCKS)
   ) u_next_ram (
      .clock  (clock),
      .wr_en  (nxt_we),
      .wr_addr(nxt_waddr),
      .wr_data(nxt_wdata),
      .rd_en  (nxt_re),
      .rd_addr(nxt_raddr),
      .rd_data(nxt_rdata)
   );

   assign alloc_bit  = cba_pkg::find_first(map_rdata);
   assign alloc_blk  = {row_ff, alloc_bit};
   assign bytes_sat  = (bytes_ff > BW'(cba_pkg::BLOCK_PAYLOAD)) ?
                       BW'(cba_pkg::BLOCK_PAYLOAD) : bytes_ff;
   assign total_base = new_chain_ff ? '0 : total_ff;
   assign total_sum  = {1'b0, total_base} + (cba_pkg::BYTES_W + 1)'(bytes_sat);

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      new_chain_in  = new_chain_ff;
      bytes_in      = bytes_ff;
      row_in        = row_ff;
      res_block_in  = res_block_ff;
      full_in       = full_ff;
      freed_in      = freed_ff;
      walk_in       = walk_ff;
      link_in       = link_ff;
      steps_in      = steps_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      map_req       = '0;
      nxt_we        = 1'b0;
      nxt_waddr     = '0;
      nxt_wdata     = '0;
      nxt_re        = 1'b0;
      nxt_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               new_chain_in = req_new_chain;
               bytes_in     = req_bytes;
               res_block_in = '0;
               full_in      = 1'b0;
               freed_in     = '0;
               state_in     = S_DONE;
               case (req_func)
                  cba_pkg::FUNC_APPEND: begin
                     if (any_free) begin
                        map_req.rd = 1'b1;
                        map_req.row = free_row;
                        row_in     = free_row;
                        state_in   = S_APP_ALLOC;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  cba_pkg::FUNC_FREE: begin
                     if (req_block != '0) begin
                        walk_in  = req_block;
                        steps_in = '0;
                        state_in = S_FREE_RD;
                     end
                  end
                  cba_pkg::FUNC_NEXT: begin
                     if (req_block != '0) begin
                        nxt_re    = 1'b1;
                        nxt_raddr = req_block;
                        state_in  = S_NXT_WAIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_APP_ALLOC: begin
            map_req.wr    = 1'b1;
            map_req.row   = row_ff;
            map_req.wdata = map_rdata & ~(cba_pkg::MAP_W'(1) << alloc_bit);
            nxt_we        = 1'b1;
            nxt_waddr     = alloc_blk;
            nxt_wdata     = '0;
            res_block_in  = alloc_blk;
            link_in       = new_chain_ff ? '0 : prev_ff;
            prev_in       = alloc_blk;
            if (new_chain_ff || head_ff == '0) head_in = alloc_blk;
            total_in = total_sum[cba_pkg::BYTES_W] ? '1 : total_sum[cba_pkg::BYTES_W-1:0];
            state_in = S_APP_LINK;
         end
         S_APP_LINK: begin
            // second write so a relinked block pointing at itself ends up self-linked
            if (link_ff != '0) begin
               nxt_we    = 1'b1;
               nxt_waddr = link_ff;
               nxt_wdata = res_block_ff;
            end
            state_in = S_DONE;
         end
         S_NXT_WAIT: begin
            res_block_in = nxt_rdata;
            state_in     = S_DONE;
         end
         S_FREE_RD: begin
            nxt_re      = 1'b1;
            nxt_raddr   = walk_ff;
            map_req.rd  = 1'b1;
            map_req.row = walk_ff[BW-1:cba_pkg::MAP_BIT_W];
            steps_in    = steps_ff + 1'b1;
            state_in    = S_FREE_UPD;
         end
         S_FREE_UPD: begin
            if (!map_rdata[walk_ff[cba_pkg::MAP_BIT_W-1:0]]) begin
               map_req.wr    = 1'b1;
               map_req.row   = walk_ff[BW-1:cba_pkg::MAP_BIT_W];
               map_req.wdata = map_rdata |
                               (cba_pkg::MAP_W'(1) << walk_ff[cba_pkg::MAP_BIT_W-1:0]);
               freed_in      = freed_ff + 1'b1;
            end
            walk_in = nxt_rdata;
            if (nxt_rdata == '0 || steps_ff == cba_pkg::STEP_W'(cba_pkg::NUM_BLOCKS)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'b0, freed_ff, total_ff, head_ff, res_block_ff};
               rsp_tuser_in  = full_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_ff       <= '0;
         head_ff       <= '0;
         total_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_chain_ff <= new_chain_in;
      bytes_ff     <= bytes_in;
      row_ff       <= row_in;
      res_block_ff <= res_block_in;
      full_ff      <= full_in;
      freed_ff     <= freed_in;
      walk_ff      <= walk_in;
      link_ff      <= link_in;
      steps_ff     <= steps_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // the row picked from the summary must hold a free block
   a_alloc_row_has_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APP_ALLOC |-> map_rdata != '0)
      else $error("allocation row has no free block");

   // a full result never carries a block
   a_full_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[11:0] == '0)
      else $error("full result with nonzero block");

   // each walked block frees at most once
   a_freed_le_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FREE_UPD |-> {1'b0, freed_ff} < steps_ff)
      else $error("freed count exceeds walk steps");

   // block 0 is never handed out
   a_alloc_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APP_ALLOC |-> alloc_blk != '0)
      else $error("block 0 allocated");

endmodule
